FILE: hdl/bpfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
`default_nettype none
package bpfa_pkg;

  localparam int MAX_PAGES  = 32768;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;

  localparam int WORD_AW = $clog2(MAP_WORDS);
  localparam int BIT_AW  = $clog2(WORD_BITS);
  localparam int PAGE_W  = WORD_AW + BIT_AW;
  localparam int ADDR_W  = 27;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;
  localparam int STAT_W  = 3;
  localparam int CIDX_W  = 4;

  localparam int IN_W  = 32;
  localparam int OUT_W = 48;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] TOTAL_LIMIT = COUNT_W'(MAX_PAGES);
  localparam logic [CFG_W-1:0]   MANAGED_RST = 16'd32768;
  localparam logic [CFG_W-1:0]   LOW_RES_RST = 16'd256;

  localparam logic [CIDX_W-1:0] CFG_MANAGED = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_LOW_RES = CIDX_W'(1);

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RESERVE,
    OP_REBUILD
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE,
    STAT_NO_FREE,
    STAT_RANGE,
    STAT_SAME,
    STAT_NULL
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RMW,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/bpfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator: control, search and map sweep.
// Usage:
//  - s_* channel takes one operation word: opcode (allocate, free address,
//    reserve page, rebuild map) and a physical byte address.
//  - m_* channel returns exactly one result word per operation: allocated
//    address, status code and the free page count after the operation.
//  - cfg_* channel writes managed_pages (index 0) and low_reserved_pages
//    (index 1); other indexes are dropped. Write only while the block is idle.
//  - One operation is in flight at a time; s_tready rises again with
//    m_tvalid, when the result is loaded. Free and reserve read the word,
//    then modify and write it. Allocate scans one bitmap word per cycle,
//    next fit, and stops at the latest when every managed word and the
//    start word again have been read. Allocate with a zero free count or
//    with no managed pages answers without a scan.
//  - Rebuild sweeps all 1024 bitmap words, one RAM write per cycle.
//  - After reset the same sweep clears all 1024 map words; s_tready
//    stays low until it is done. Config writes are taken throughout.
//  - A result waiting on a stalled m_tready does not block the next accept;
//    only the following result holds in its final state until the output
//    register frees up.
`default_nettype none
module bitmap_page_frame_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // [1:0] opcode, [28:2] phys_address, [31:29] zero
  input  wire logic [bpfa_pkg::IN_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [26:0] result_address, [29:27] status, [45:30] free_count, [47:46] zero
  output logic      [bpfa_pkg::OUT_W-1:0] m_tdata,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bpfa_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [bpfa_pkg::CFG_W-1:0] cfg_data
);
  import bpfa_pkg::*;

  // Registers
  state_t               state, state_next;
  logic [CFG_W-1:0]     managed_pages, low_reserved_pages;
  logic [COUNT_W-1:0]   free_count, free_count_next;
  logic [PAGE_W-1:0]    search_start, search_start_next;
  logic [WORD_AW-1:0]   cur_word, cur_word_next;
  logic                 cur_wrap, cur_wrap_next;
  logic [WORD_AW-1:0]   origin_word, origin_word_next;
  logic [BIT_AW-1:0]    origin_bit, origin_bit_next;
  opcode_t              op_reg, op_reg_next;
  logic [PAGE_W-1:0]    page_reg, page_reg_next;
  logic                 addr_zero, addr_zero_next;
  logic [WORD_AW-1:0]   sweep_word, sweep_word_next;
  logic [COUNT_W-1:0]   sweep_low, sweep_low_next;
  logic                 sweep_reply, sweep_reply_next;
  logic [ADDR_W-1:0]    res_addr, res_addr_next;
  status_t              res_status, res_status_next;

  // Memory port
  logic                 ram_we;
  logic [WORD_AW-1:0]   ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  bpfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Input word fields
  opcode_t            in_op;
  logic [ADDR_W-1:0]  in_addr;
  logic [PAGE_W-1:0]  in_page;
  logic               in_accept;

  assign in_op     = opcode_t'(s_tdata[1:0]);
  assign in_addr   = s_tdata[ADDR_W+1:2];
  assign in_page   = in_addr[ADDR_W-1:PAGE_SHIFT];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Effective page total and derived limits
  logic [COUNT_W-1:0] total, total_m1, low_eff;
  logic [WORD_AW-1:0] last_word;
  logic [BIT_AW-1:0]  last_bit;
  logic               total_zero;

  assign total      = (managed_pages > TOTAL_LIMIT) ? TOTAL_LIMIT : managed_pages;
  assign total_zero = (total == '0);
  assign total_m1   = total - COUNT_W'(1);
  assign last_word  = total_m1[PAGE_W-1:BIT_AW];
  assign last_bit   = total_m1[BIT_AW-1:0];
  assign low_eff    = (low_reserved_pages < total) ? low_reserved_pages : total;

  // Search start clipped to the managed range
  logic [PAGE_W-1:0] eff_start;
  assign eff_start = ({1'b0, search_start} < total) ? search_start : '0;

  // Scan window over the word now returned by the RAM
  logic [WORD_BITS-1:0] scan_mask, free_bits;
  logic                 found_any;
  logic [BIT_AW-1:0]    found_bit;
  logic                 at_start, at_last, scan_exhausted;

  assign at_start = (cur_word == origin_word);
  assign at_last  = (cur_word == last_word);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      scan_mask[b] = (cur_wrap || !at_start || (BIT_AW'(b) >= origin_bit)) &&
                     (!(cur_wrap && at_start) || (BIT_AW'(b) < origin_bit)) &&
                     (!at_last || (BIT_AW'(b) <= last_bit));
    end
  end

  assign free_bits = ~ram_rdata & scan_mask;
  assign found_any = |free_bits;
  assign scan_exhausted = cur_wrap && at_start;

  // Lowest free bit
  always_comb begin
    found_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_bit = BIT_AW'(b);
      end
    end
  end

  // Word pattern for the map sweep
  logic [COUNT_W-BIT_AW-1:0] sweep_full_words;
  logic [BIT_AW-1:0]         sweep_rem;
  logic [WORD_BITS-1:0]      sweep_pattern;

  assign sweep_full_words = sweep_low[COUNT_W-1:BIT_AW];
  assign sweep_rem        = sweep_low[BIT_AW-1:0];

  always_comb begin
    if ((COUNT_W-BIT_AW)'(sweep_word) < sweep_full_words) begin
      sweep_pattern = '1;
    end else if ((COUNT_W-BIT_AW)'(sweep_word) == sweep_full_words) begin
      sweep_pattern = (WORD_BITS'(1) << sweep_rem) - WORD_BITS'(1);
    end else begin
      sweep_pattern = '0;
    end
  end

  // Read-modify-write view of the addressed page
  logic               page_bit, page_out;
  logic [WORD_BITS-1:0] page_onehot;

  assign page_onehot = WORD_BITS'(1) << page_reg[BIT_AW-1:0];
  assign page_bit    = ram_rdata[page_reg[BIT_AW-1:0]];
  assign page_out    = ({1'b0, page_reg} >= total);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_ALLOC: begin
              if (free_count == '0 || total_zero) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_SCAN;
              end
            end
            OP_REBUILD: state_next = ST_SWEEP;
            default:    state_next = ST_RMW;
          endcase
        end
      end
      ST_SCAN: begin
        if (found_any || scan_exhausted) begin
          state_next = ST_DONE;
        end
      end
      ST_RMW: state_next = ST_DONE;
      ST_SWEEP: begin
        if (sweep_word == WORD_AW'(MAP_WORDS - 1)) begin
          state_next = sweep_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    free_count_next   = free_count;
    search_start_next = search_start;
    cur_word_next     = cur_word;
    cur_wrap_next     = cur_wrap;
    origin_word_next  = origin_word;
    origin_bit_next   = origin_bit;
    op_reg_next       = op_reg;
    page_reg_next     = page_reg;
    addr_zero_next    = addr_zero;
    sweep_word_next   = sweep_word;
    sweep_low_next    = sweep_low;
    sweep_reply_next  = sweep_reply;
    res_addr_next     = res_addr;
    res_status_next   = res_status;
    ram_we            = 1'b0;
    ram_waddr         = cur_word;
    ram_wdata         = ram_rdata;
    ram_raddr         = cur_word;

    case (state)
      ST_IDLE: begin
        // Capture the operation and launch the first read
        op_reg_next      = in_op;
        page_reg_next    = in_page;
        addr_zero_next   = (in_addr == '0);
        origin_word_next = eff_start[PAGE_W-1:BIT_AW];
        origin_bit_next  = eff_start[BIT_AW-1:0];
        cur_word_next    = eff_start[PAGE_W-1:BIT_AW];
        cur_wrap_next    = 1'b0;
        res_addr_next    = '0;
        res_status_next  = STAT_DONE;
        if (in_op == OP_ALLOC) begin
          ram_raddr = eff_start[PAGE_W-1:BIT_AW];
        end else begin
          ram_raddr = in_page[PAGE_W-1:BIT_AW];
        end
        if (in_accept) begin
          if (in_op == OP_ALLOC && (free_count == '0 || total_zero)) begin
            res_status_next = STAT_NO_FREE;
          end
          if (in_op == OP_REBUILD) begin
            sweep_word_next   = '0;
            sweep_low_next    = low_eff;
            sweep_reply_next  = 1'b1;
            free_count_next   = total - low_eff;
            search_start_next = '0;
          end
        end
      end
      ST_SCAN: begin
        // Advance the read one word ahead while testing the returned word
        if (at_last) begin
          cur_word_next = '0;
        end else begin
          cur_word_next = cur_word + WORD_AW'(1);
        end
        cur_wrap_next = cur_wrap || at_last;
        ram_raddr     = cur_word_next;
        if (found_any) begin
          ram_we            = 1'b1;
          ram_waddr         = cur_word;
          ram_wdata         = ram_rdata | (WORD_BITS'(1) << found_bit);
          search_start_next = {cur_word, found_bit};
          res_addr_next     = {cur_word, found_bit, {PAGE_SHIFT{1'b0}}};
          res_status_next   = STAT_DONE;
          if (free_count != '0) begin
            free_count_next = free_count - COUNT_W'(1);
          end
        end else if (scan_exhausted) begin
          res_status_next = STAT_NO_FREE;
        end
      end
      ST_RMW: begin
        ram_waddr = page_reg[PAGE_W-1:BIT_AW];
        ram_raddr = page_reg[PAGE_W-1:BIT_AW];
        if (op_reg == OP_FREE) begin
          if (addr_zero) begin
            res_status_next = STAT_NULL;
          end else if (page_out) begin
            res_status_next = STAT_RANGE;
          end else if (!page_bit) begin
            res_status_next = STAT_SAME;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~page_onehot;
            if (free_count != COUNT_MAX) begin
              free_count_next = free_count + COUNT_W'(1);
            end
          end
        end else begin
          if (page_out) begin
            res_status_next = STAT_RANGE;
          end else if (page_bit) begin
            res_status_next = STAT_SAME;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | page_onehot;
            if (free_count != '0) begin
              free_count_next = free_count - COUNT_W'(1);
            end
          end
        end
      end
      ST_SWEEP: begin
        ram_we          = 1'b1;
        ram_waddr       = sweep_word;
        ram_wdata       = sweep_pattern;
        sweep_word_next = sweep_word + WORD_AW'(1);
      end
      default: begin
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_SWEEP;
      managed_pages      <= MANAGED_RST;
      low_reserved_pages <= LOW_RES_RST;
      free_count         <= TOTAL_LIMIT;
      search_start       <= '0;
      sweep_word         <= '0;
      sweep_low          <= '0;
      sweep_reply        <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      state        <= state_next;
      free_count   <= free_count_next;
      search_start <= search_start_next;
      sweep_word   <= sweep_word_next;
      sweep_low    <= sweep_low_next;
      sweep_reply  <= sweep_reply_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MANAGED) begin
          managed_pages <= cfg_data;
        end else if (cfg_index == CFG_LOW_RES) begin
          low_reserved_pages <= cfg_data;
        end
      end
      // Load the output register when a result is ready, drop it when taken
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_word    <= cur_word_next;
    cur_wrap    <= cur_wrap_next;
    origin_word <= origin_word_next;
    origin_bit  <= origin_bit_next;
    op_reg      <= op_reg_next;
    page_reg    <= page_reg_next;
    addr_zero   <= addr_zero_next;
    res_addr    <= res_addr_next;
    res_status  <= res_status_next;
    if (state == ST_DONE && out_free) begin
      m_tdata <= {2'b00, free_count, res_status, res_addr};
    end
  end

endmodule
`default_nettype wire
